@@ src/epsf_pkg.sv @@
// Shared types and constants for the IR edge pulse/space filter.
`timescale 1ns / 1ps

package epsf_pkg;

  localparam int REG_BITS = 24;
  localparam int SECS_BITS = 8;
  localparam int CFG_INDEX_BITS = 2;
  localparam int IN_DATA_BITS = 40;

  localparam logic [SECS_BITS-1:0] SECONDS_LIMIT = 8'd15;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_SENSE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AUTO_SENSE = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PULSE_THRESHOLD = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPACE_THRESHOLD = 2'd3;

  localparam logic RST_INITIAL_SENSE = 1'b1;
  localparam logic RST_AUTO_SENSE = 1'b1;
  localparam logic [REG_BITS-1:0] RST_PULSE_THRESHOLD = 24'd250;
  localparam logic [REG_BITS-1:0] RST_SPACE_THRESHOLD = 24'd20000;

  typedef struct packed {
    logic                initial_sense;
    logic                auto_sense_enable;
    logic [REG_BITS-1:0] pulse_release_threshold;
    logic [REG_BITS-1:0] long_space_threshold;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic value;
  } sense_load_t;

  typedef struct packed {
    logic                time_backwards;
    logic [REG_BITS-1:0] elapsed_us;
    logic [SECS_BITS-1:0] whole_seconds_diff;
    logic                pin_level;
  } edge_t;

  typedef struct packed {
    logic [REG_BITS-1:0] duration_us;
    logic                is_pulse;
  } res_t;

  typedef struct packed {
    logic [1:0]     count;
    res_t [2:0]     item;
  } res_group_t;

endpackage

@@ src/ir_edge_pulse_space_filter_unit.sv @@
// Top level of the IR edge pulse/space filter.
//
//   Channel  Dir  Handshake             Item
//   s_*      in   s_tvalid / s_tready   edge: level, seconds, microseconds, backwards flag
//   m_*      out  m_tvalid / m_tready   duration with pulse flag in tuser, tlast ends an edge
//   cfg_*    in   cfg_valid / cfg_ready register index and write data
//
// An edge waits in the input register, where the filter computes all of its results and
// loads them into the result buffer. The first result of an edge is offered from the
// result buffer, which lies after the input register. The result buffer sends one result
// a cycle while m_tready is high, so an edge that makes several results holds it until
// all are sent; edges making at most one result flow at one per cycle while m_tready is
// high. Reset restores the register defaults and clears the filter state.
`timescale 1ns / 1ps

module ir_edge_pulse_space_filter_unit import epsf_pkg::*; #(
  parameter int DURATION_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // pin_level [0], whole_seconds_diff [8:1], elapsed_us [32:9], time_backwards [33]
  input  logic [IN_DATA_BITS-1:0]   s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // duration_us [23:0]
  output logic [REG_BITS-1:0]       m_tdata,
  // is_pulse [0]
  output logic                      m_tuser,
  output logic                      m_tlast,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]       cfg_data
);

  cfg_t        cfg;
  sense_load_t sense_load;
  edge_t       in_item;
  logic        in_valid;
  logic        seq_ready;
  logic        consume;
  res_group_t  res;

  assign consume = in_valid & seq_ready;
  assign s_tready = !in_valid || seq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item <= edge_t'(s_tdata[$bits(edge_t)-1:0]);
    end
  end

  epsf_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg        (cfg),
    .sense_load (sense_load)
  );

  epsf_filter #(
    .DURATION_BITS (DURATION_BITS)
  ) u_filter (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .sense_load (sense_load),
    .item       (in_item),
    .fire       (consume),
    .res        (res)
  );

  epsf_out_seq u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (in_valid),
    .load_ready (seq_ready),
    .res        (res),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !consume) |=> (in_valid && $stable(in_item)))
    else $error("Input register lost a waiting item.");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (consume && (res.count != 2'd0)) |=> m_tvalid)
    else $error("Loaded results did not reach the output.");

  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast && !(consume && (res.count != 2'd0))) |=> !m_tvalid)
    else $error("Output stayed valid after the last result of an edge.");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> seq_ready)
    else $error("Empty result buffer refused an item.");

endmodule

@@ src/epsf_cfg.sv @@
// Configuration register file for the IR edge pulse/space filter.
`timescale 1ns / 1ps

module epsf_cfg import epsf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [REG_BITS-1:0]       cfg_data,
  output cfg_t                      cfg,
  output sense_load_t               sense_load
);

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr = cfg_valid & cfg_ready;

  assign sense_load.load = wr && (cfg_index == CFG_INITIAL_SENSE);
  assign sense_load.value = cfg_data[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_sense <= RST_INITIAL_SENSE;
      cfg.auto_sense_enable <= RST_AUTO_SENSE;
      cfg.pulse_release_threshold <= RST_PULSE_THRESHOLD;
      cfg.long_space_threshold <= RST_SPACE_THRESHOLD;
    end else if (wr) begin
      case (cfg_index)
        CFG_INITIAL_SENSE: cfg.initial_sense <= cfg_data[0];
        CFG_AUTO_SENSE: cfg.auto_sense_enable <= cfg_data[0];
        CFG_PULSE_THRESHOLD: cfg.pulse_release_threshold <= cfg_data;
        CFG_SPACE_THRESHOLD: cfg.long_space_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ src/epsf_filter.sv @@
// Duration measurement, polarity tracking and long-space noise filter.
`timescale 1ns / 1ps

module epsf_filter import epsf_pkg::*; #(
  parameter int DURATION_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  sense_load_t sense_load,
  input  edge_t       item,
  input  logic        fire,
  output res_group_t  res
);

  localparam int W = DURATION_BITS;
  localparam int EW = (DURATION_BITS > REG_BITS) ? DURATION_BITS : REG_BITS;
  localparam logic [W-1:0] DUR_MAX = {W{1'b1}};

  logic         active_sense;
  logic         space_held;
  logic [W-1:0] pulse_sum;
  logic [W-1:0] space_sum;

  logic         active_sense_next;
  logic         space_held_next;
  logic [W-1:0] pulse_sum_next;
  logic [W-1:0] space_sum_next;

  logic [EW-1:0] us_ext;
  logic [W-1:0]  dur;
  logic          sense_flip;
  logic          pulse;
  logic          long_space;
  logic [W-1:0]  psum_add;
  logic [W-1:0]  space_add1;
  logic [W-1:0]  space_add2;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? DUR_MAX : s[W-1:0];
  endfunction

  function automatic logic [REG_BITS-1:0] to_reg(input logic [W-1:0] v);
    logic [EW-1:0] e;
    e = EW'(v);
    return e[REG_BITS-1:0];
  endfunction

  assign us_ext = EW'(item.elapsed_us);
  assign sense_flip = !item.time_backwards && (item.whole_seconds_diff > SECONDS_LIMIT) &&
                      (item.pin_level == active_sense) && cfg.auto_sense_enable;
  assign active_sense_next = active_sense ^ sense_flip;
  assign pulse = (item.pin_level == active_sense_next);

  always_comb begin
    if (item.time_backwards || (item.whole_seconds_diff > SECONDS_LIMIT)) begin
      dur = DUR_MAX;
    end else if (us_ext > EW'(DUR_MAX)) begin
      dur = DUR_MAX;
    end else begin
      dur = W'(us_ext);
    end
  end

  assign long_space = EW'(dur) > EW'(cfg.long_space_threshold);
  assign psum_add = sat_add(pulse_sum, dur);
  assign space_add1 = sat_add(space_sum, pulse_sum);
  assign space_add2 = sat_add(space_add1, dur);

  always_comb begin
    res = '0;
    space_held_next = space_held;
    pulse_sum_next = pulse_sum;
    space_sum_next = space_sum;
    if (space_held && pulse) begin
      pulse_sum_next = psum_add;
      if (EW'(psum_add) > EW'(cfg.pulse_release_threshold)) begin
        res.count = 2'd2;
        res.item[0] = '{duration_us: to_reg(space_sum), is_pulse: 1'b0};
        res.item[1] = '{duration_us: to_reg(psum_add), is_pulse: 1'b1};
        space_held_next = 1'b0;
        pulse_sum_next = '0;
      end
    end else if (!pulse && !space_held && long_space) begin
      space_sum_next = dur;
      space_held_next = 1'b1;
    end else if (!pulse && space_held && long_space) begin
      space_sum_next = space_add2;
      pulse_sum_next = '0;
    end else if (!pulse && space_held) begin
      res.count = 2'd3;
      res.item[0] = '{duration_us: to_reg(space_sum), is_pulse: 1'b0};
      res.item[1] = '{duration_us: to_reg(pulse_sum), is_pulse: 1'b1};
      res.item[2] = '{duration_us: to_reg(dur), is_pulse: 1'b0};
      space_held_next = 1'b0;
      pulse_sum_next = '0;
    end else begin
      res.count = 2'd1;
      res.item[0] = '{duration_us: to_reg(dur), is_pulse: pulse};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_sense <= RST_INITIAL_SENSE;
      space_held <= 1'b0;
      pulse_sum <= '0;
      space_sum <= '0;
    end else if (sense_load.load) begin
      active_sense <= sense_load.value;
    end else if (fire) begin
      active_sense <= active_sense_next;
      space_held <= space_held_next;
      pulse_sum <= pulse_sum_next;
      space_sum <= space_sum_next;
    end
  end

endmodule

@@ src/epsf_out_seq.sv @@
// Result buffer that sends up to three results of one edge in order.
`timescale 1ns / 1ps

module epsf_out_seq import epsf_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  output logic                load_ready,
  input  res_group_t          res,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [REG_BITS-1:0] m_tdata,
  output logic                m_tuser,
  output logic                m_tlast
);

  res_t [2:0] buffer;
  logic [1:0] rem;
  logic       load;
  logic       fire;

  assign m_tvalid = (rem != 2'd0);
  assign fire = m_tvalid & m_tready;
  assign load_ready = (rem == 2'd0) || ((rem == 2'd1) && m_tready);
  assign load = load_valid & load_ready;

  assign m_tdata = buffer[0].duration_us;
  assign m_tuser = buffer[0].is_pulse;
  assign m_tlast = (rem == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= res.count;
    end else if (fire) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buffer <= res.item;
    end else if (fire) begin
      buffer[0] <= buffer[1];
      buffer[1] <= buffer[2];
    end
  end

endmodule

@@ dv/tb_ir_edge_pulse_space_filter_unit.sv @@
// Self-checking testbench for the IR edge pulse/space filter: directed edges, then random edges.
`timescale 1ns / 1ps

module tb_ir_edge_pulse_space_filter_unit;
  import epsf_pkg::*;

  localparam int HOLD_OFF_CYCLES = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES = 5;
  localparam int EDGES_PER_PHASE = 25;
  localparam logic [REG_BITS-1:0] DUR_ALL_ONES = '1;

  typedef struct packed {
    logic [REG_BITS-1:0] duration;
    logic                is_pulse;
    logic                last;
  } pulse_space_t;

  typedef struct packed {
    bit                        is_reg;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [REG_BITS-1:0]       data;
    edge_t                     ir_edge;
    bit                        typed;
    pulse_space_t              want;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_DATA_BITS-1:0]   s_tdata = '0;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [REG_BITS-1:0]       m_tdata;
  logic                      m_tuser;
  logic                      m_tlast;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [REG_BITS-1:0]       cfg_data = '0;

  ir_edge_pulse_space_filter_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Filter state and register copies.
  logic                init_sense = RST_INITIAL_SENSE;
  logic                auto_en = RST_AUTO_SENSE;
  logic [REG_BITS-1:0] pulse_thr = RST_PULSE_THRESHOLD;
  logic [REG_BITS-1:0] space_thr = RST_SPACE_THRESHOLD;
  logic                sense = RST_INITIAL_SENSE;
  logic                space_held = 1'b0;
  logic [REG_BITS-1:0] pulse_acc = '0;
  logic [REG_BITS-1:0] space_acc = '0;

  pulse_space_t pending_durations[$];
  pulse_space_t edge_results[$];
  stim_row_t    plan[$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;
  bit  hold_off_req = 1'b0;

  function automatic logic [REG_BITS-1:0] sat_add(logic [REG_BITS-1:0] a,
                                                  logic [REG_BITS-1:0] b);
    logic [REG_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[REG_BITS] ? DUR_ALL_ONES : s[REG_BITS-1:0];
  endfunction

  function automatic void emit(logic [REG_BITS-1:0] dur, logic pulse);
    edge_results.push_back('{duration: dur, is_pulse: pulse, last: 1'b0});
  endfunction

  // Computes the results of one edge into edge_results and advances the filter state.
  function automatic void filter_edge(edge_t e);
    logic [REG_BITS-1:0] dur;
    logic                pulse;
    edge_results.delete();
    if (e.time_backwards) begin
      dur = DUR_ALL_ONES;
    end else if (e.whole_seconds_diff > SECONDS_LIMIT) begin
      dur = DUR_ALL_ONES;
      if (e.pin_level == sense && auto_en) begin
        sense = ~sense;
      end
    end else begin
      dur = e.elapsed_us;
    end
    pulse = (e.pin_level == sense);
    if (space_held && pulse) begin
      pulse_acc = sat_add(pulse_acc, dur);
      if (pulse_acc > pulse_thr) begin
        emit(space_acc, 1'b0);
        emit(pulse_acc, 1'b1);
        space_held = 1'b0;
        pulse_acc = '0;
      end
    end else if (!pulse && dur > space_thr) begin
      if (space_held) begin
        space_acc = sat_add(sat_add(space_acc, pulse_acc), dur);
      end else begin
        space_acc = dur;
      end
      space_held = 1'b1;
      pulse_acc = '0;
    end else begin
      if (space_held) begin
        emit(space_acc, 1'b0);
        emit(pulse_acc, 1'b1);
        space_held = 1'b0;
        pulse_acc = '0;
      end
      emit(dur, pulse);
    end
    if (edge_results.size() > 0) begin
      edge_results[$].last = 1'b1;
    end
  endfunction

  function automatic stim_row_t edge_row(bit lvl, int secs, int us, bit back,
                                         bit typed = 1'b0, int dur = 0, bit pulse = 1'b0);
    stim_row_t r;
    r = '0;
    r.ir_edge.pin_level = lvl;
    r.ir_edge.whole_seconds_diff = SECS_BITS'(secs);
    r.ir_edge.elapsed_us = REG_BITS'(us);
    r.ir_edge.time_backwards = back;
    r.typed = typed;
    r.want = '{duration: REG_BITS'(dur), is_pulse: pulse, last: 1'b1};
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CFG_INDEX_BITS-1:0] idx, int data);
    stim_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.index = idx;
    r.data = REG_BITS'(data);
    return r;
  endfunction

  // Mostly well-formed IR traffic relative to the current polarity, with some noise.
  function automatic edge_t random_edge();
    edge_t       e;
    int unsigned pick;
    int unsigned hi;
    e = '0;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      e.pin_level = ~sense;
      if (space_thr == DUR_ALL_ONES) begin
        e.elapsed_us = DUR_ALL_ONES;
      end else begin
        hi = space_thr + 100000;
        if (hi > DUR_ALL_ONES) hi = DUR_ALL_ONES;
        e.elapsed_us = REG_BITS'($urandom_range(hi, space_thr + 1));
      end
    end else if (pick < 55) begin
      e.pin_level = sense;
      e.elapsed_us = REG_BITS'($urandom_range(1, 700));
    end else if (pick < 85) begin
      e.pin_level = ~sense;
      hi = (space_thr < 3000) ? space_thr : 3000;
      e.elapsed_us = REG_BITS'($urandom_range(0, hi));
    end else begin
      e.pin_level = 1'($urandom_range(0, 1));
      e.whole_seconds_diff = $urandom_range(0, 1) ? SECS_BITS'($urandom_range(0, 255))
                                                  : SECS_BITS'($urandom_range(0, 15));
      e.elapsed_us = REG_BITS'($urandom);
      e.time_backwards = ($urandom_range(0, 3) == 0);
    end
    return e;
  endfunction

  task automatic send_edge(edge_t e, bit typed, pulse_space_t want);
    cfg_valid <= 1'b0;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tdata <= IN_DATA_BITS'(e);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    filter_edge(e);
    if (typed) begin
      pending_durations.push_back(want);
    end else begin
      foreach (edge_results[k]) pending_durations.push_back(edge_results[k]);
    end
  endtask

  // Lowers the item valid and waits until every result is out and the block has settled.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_durations.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [REG_BITS-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      CFG_INITIAL_SENSE: begin
        init_sense = data[0];
        sense = data[0];
      end
      CFG_AUTO_SENSE: auto_en = data[0];
      CFG_PULSE_THRESHOLD: pulse_thr = data;
      CFG_SPACE_THRESHOLD: space_thr = data;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    pulse_space_t exp_item;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_durations.size() == 0) begin
        if (fail_count < 10) begin
          $display("Unexpected result: duration %h pulse %b last %b",
                   m_tdata, m_tuser, m_tlast);
        end
        fail_count++;
      end else begin
        exp_item = pending_durations.pop_front();
        if (m_tdata !== exp_item.duration || m_tuser !== exp_item.is_pulse ||
            m_tlast !== exp_item.last) begin
          if (fail_count < 10) begin
            $display("Mismatch: expected duration %h pulse %b last %b, got %h %b %b",
                     exp_item.duration, exp_item.is_pulse, exp_item.last,
                     m_tdata, m_tuser, m_tlast);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Result receiver: random stall bursts plus one long hold-off on request.
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        m_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  initial begin
    plan.push_back(edge_row(1, 0, 500, 0, 1, 500, 1));
    plan.push_back(edge_row(0, 0, 0, 0, 1, 0, 0));
    plan.push_back(edge_row(0, 0, 20000, 0, 1, 20000, 0));
    plan.push_back(edge_row(1, 15, 'hFFFFFF, 0, 1, 'hFFFFFF, 1));
    plan.push_back(edge_row(1, 255, 7, 1, 1, 'hFFFFFF, 1));
    plan.push_back(edge_row(0, 16, 100, 0));
    plan.push_back(edge_row(1, 0, 100, 0));
    plan.push_back(edge_row(1, 0, 200, 0));
    plan.push_back(edge_row(0, 0, 30000, 0));
    plan.push_back(edge_row(0, 0, 25000, 0));
    plan.push_back(edge_row(1, 0, 50, 0));
    plan.push_back(edge_row(0, 0, 1000, 0));
    plan.push_back(edge_row(1, 200, 0, 0));
    plan.push_back(edge_row(1, 0, 300, 0));
    plan.push_back(reg_row(CFG_AUTO_SENSE, 0));
    plan.push_back(reg_row(CFG_INITIAL_SENSE, 0));
    plan.push_back(reg_row(CFG_PULSE_THRESHOLD, 'hFFFFFF));
    plan.push_back(edge_row(0, 255, 0, 0, 1, 'hFFFFFF, 1));
    plan.push_back(edge_row(1, 0, 'hFFFFFF, 0));
    plan.push_back(edge_row(1, 16, 0, 0));
    plan.push_back(edge_row(0, 0, 'hFFFFFF, 0));
    plan.push_back(edge_row(0, 0, 'hFFFFFF, 0));
    plan.push_back(edge_row(1, 0, 5, 0));
    plan.push_back(reg_row(CFG_SPACE_THRESHOLD, 0));
    plan.push_back(reg_row(CFG_PULSE_THRESHOLD, 0));
    plan.push_back(edge_row(1, 0, 1, 0));
    plan.push_back(edge_row(0, 0, 0, 0));
    plan.push_back(edge_row(1, 0, 0, 0));
    plan.push_back(edge_row(1, 0, 3, 0));
    plan.push_back(edge_row(0, 0, 1, 0));
    plan.push_back(reg_row(CFG_SPACE_THRESHOLD, 'hFFFFFF));
    plan.push_back(edge_row(1, 0, 'hFFFFFF, 0, 1, 'hFFFFFF, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        wait_drained();
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_edge(plan[i].ir_edge, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      tx_idle_on = (phase < PHASES - 1);
      rx_idle_on = (phase < PHASES - 1);
      write_reg(CFG_INITIAL_SENSE, REG_BITS'($urandom_range(0, 1)));
      case (phase)
        0: begin
          write_reg(CFG_AUTO_SENSE, REG_BITS'(1));
          write_reg(CFG_PULSE_THRESHOLD, RST_PULSE_THRESHOLD);
          write_reg(CFG_SPACE_THRESHOLD, RST_SPACE_THRESHOLD);
        end
        1: begin
          write_reg(CFG_AUTO_SENSE, REG_BITS'($urandom_range(0, 1)));
          write_reg(CFG_PULSE_THRESHOLD, REG_BITS'(0));
          write_reg(CFG_SPACE_THRESHOLD, REG_BITS'(0));
        end
        2: begin
          write_reg(CFG_AUTO_SENSE, REG_BITS'(1));
          write_reg(CFG_PULSE_THRESHOLD, DUR_ALL_ONES);
          write_reg(CFG_SPACE_THRESHOLD, DUR_ALL_ONES);
        end
        default: begin
          write_reg(CFG_AUTO_SENSE, REG_BITS'($urandom_range(0, 1)));
          write_reg(CFG_PULSE_THRESHOLD, REG_BITS'($urandom_range(0, 2000)));
          write_reg(CFG_SPACE_THRESHOLD, REG_BITS'($urandom_range(1000, 50000)));
        end
      endcase
      if (phase == 2) hold_off_req = 1'b1;
      repeat (EDGES_PER_PHASE) send_edge(random_edge(), 1'b0, '0);
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/epsf_pkg.sv
src/epsf_cfg.sv
src/epsf_filter.sv
src/epsf_out_seq.sv
src/ir_edge_pulse_space_filter_unit.sv
dv/tb_ir_edge_pulse_space_filter_unit.sv
